### hw/rtl/pcu_pkg.sv
package pcu_pkg;

   // Number of counter lanes in the bank
   localparam int NUM_COUNTERS = 8;

   // Register map and masks
   localparam logic [31:0] CTRL_MASK   = 32'hffff1ff9;
   localparam logic [3:0]  ACCESS_WORD = 4'd4;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   // Offset bits 8:7 pick the register region
   typedef enum logic [1:0] {
      REGION_GLOBAL  = 2'd0,
      REGION_COUNTER = 2'd1,
      REGION_CONTROL = 2'd2,
      REGION_STATUS  = 2'd3
   } region_type;

   // Per-lane command from the bank decoder
   typedef struct packed {
      logic        value_we;
      logic        control_we;
      logic        status_we;
      logic        tick;
      logic        too_wide;
      logic        irq_prev;
      logic [31:0] data;
      logic [31:0] cycles;
   } lane_cmd_type;

   // Per-lane state seen by the bank
   typedef struct packed {
      logic        ovf;
      logic        intr;
      logic        ovf_next;
      logic [31:0] value;
      logic [31:0] control;
   } lane_stat_type;

endpackage

### hw/rtl/pcu_counter.sv
module pcu_counter
   import pcu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lane_cmd_type  cmd,
   output lane_stat_type stat
);

   logic [31:0] value_ff, value_in;
   logic [31:0] control_ff, control_in;
   logic        ovf_ff, ovf_in;
   logic        intr_ff, intr_in;

   logic        selected;
   logic [31:0] sum;
   logic        ovf_hit;

   // Tick adder and overflow test (bit 31 falling, or forced)
   assign selected = |control_ff[31:16];
   assign sum      = value_ff + cmd.cycles;
   assign ovf_hit  = (value_ff[31] & ~sum[31]) | cmd.too_wide;

   // Next state
   always_comb begin
      value_in   = value_ff;
      control_in = control_ff;
      ovf_in     = ovf_ff;
      intr_in    = intr_ff;
      if (cmd.value_we) begin
         value_in = cmd.data;
      end
      if (cmd.control_we) begin
         control_in = cmd.data & CTRL_MASK;
      end
      if (cmd.status_we) begin
         ovf_in  = ovf_ff & ~cmd.data[0];
         intr_in = intr_ff & ~cmd.data[4];
      end
      if (cmd.tick && selected) begin
         value_in = sum;
         if (ovf_hit) begin
            ovf_in = 1'b1;
            if (control_ff[0] && !cmd.irq_prev) begin
               intr_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff   <= '0;
         control_ff <= '0;
         ovf_ff     <= 1'b0;
         intr_ff    <= 1'b0;
      end else begin
         value_ff   <= value_in;
         control_ff <= control_in;
         ovf_ff     <= ovf_in;
         intr_ff    <= intr_in;
      end
   end

   assign stat.ovf      = ovf_ff;
   assign stat.intr     = intr_ff;
   assign stat.ovf_next = ovf_in;
   assign stat.value    = value_ff;
   assign stat.control  = control_ff;

endmodule

### hw/rtl/pcu_bank.sv
module pcu_bank
   import pcu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        exec,
   input  logic [1:0]  operation,
   input  logic [8:0]  byte_offset,
   input  logic [3:0]  access_bytes,
   input  logic [31:0] write_data,
   input  logic [31:0] elapsed_cycles,
   input  logic        elapsed_too_wide,
   output logic [31:0] read_data,
   output logic        irq_next
);

   logic          enable_ff, enable_in;
   logic          irq_ff, irq_in;
   logic          access_ok;
   logic          is_read, is_write, is_tick;
   region_type    region;
   logic [4:0]    slot;
   logic          global_hit;
   lane_cmd_type  cmd [NUM_COUNTERS];
   lane_stat_type stat [NUM_COUNTERS];
   logic [NUM_COUNTERS-1:0] ovf_next_vec;

   // Decode of the word
   assign access_ok  = (byte_offset[1:0] == 2'b00) && (access_bytes == ACCESS_WORD);
   assign is_read    = exec && (operation == OP_READ) && access_ok;
   assign is_write   = exec && (operation == OP_WRITE) && access_ok;
   assign is_tick    = exec && (operation == OP_TICK) && enable_ff;
   assign region     = region_type'(byte_offset[8:7]);
   assign slot       = byte_offset[6:2];
   assign global_hit = (region == REGION_GLOBAL) && (slot == 5'd0);

   // Counter lanes
   for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_lane
      always_comb begin
         cmd[i].value_we   = is_write && (region == REGION_COUNTER) && (slot == 5'(i));
         cmd[i].control_we = is_write && (region == REGION_CONTROL) && (slot == 5'(i));
         cmd[i].status_we  = is_write && (region == REGION_STATUS) && (slot == 5'(i));
         cmd[i].tick       = is_tick;
         cmd[i].too_wide   = elapsed_too_wide;
         cmd[i].irq_prev   = irq_ff;
         cmd[i].data       = write_data;
         cmd[i].cycles     = elapsed_cycles;
      end

      pcu_counter u_counter (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd[i]),
         .stat  (stat[i])
      );

      assign ovf_next_vec[i] = stat[i].ovf_next;
   end

   // Read mux
   always_comb begin
      read_data = '0;
      if (is_read) begin
         if (global_hit) begin
            read_data = {31'd0, enable_ff};
         end
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            if (slot == 5'(i)) begin
               case (region)
                  REGION_COUNTER: read_data = stat[i].value;
                  REGION_CONTROL: read_data = stat[i].control;
                  REGION_STATUS:  read_data = {27'd0, stat[i].intr, 3'd0, stat[i].ovf};
                  default:        ;
               endcase
            end
         end
      end
   end

   // Global enable and interrupt level
   assign enable_in = (is_write && global_hit) ? write_data[0] : enable_ff;
   assign irq_in    = enable_in & (|ovf_next_vec);
   assign irq_next  = irq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         irq_ff    <= 1'b0;
      end else begin
         enable_ff <= enable_in;
         irq_ff    <= irq_in;
      end
   end

endmodule

### hw/rtl/cycle_performance_counter_unit.sv
// Performance counter bank: a global enable and eight 32-bit counters, each
// with a control and a status register, reached through bus read and write
// words; a tick adds elapsed cycles to every selected counter while enabled.
// Every word gives one response carrying read data (zero for writes, ticks
// and ignored accesses) and the interrupt level after the word. A word is
// registered on entry, executed against the register bank when the response
// register can take its result, and its response registered, so one word is
// taken every clock while rsp_stall is low. The response register
// lets a new word enter while a finished response waits on rsp_stall.
module cycle_performance_counter_unit
   import pcu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [8:0]  req_byte_offset,
   input  logic [3:0]  req_access_bytes,
   input  logic [31:0] req_write_data,
   input  logic [31:0] req_elapsed_cycles,
   input  logic        req_elapsed_too_wide,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_line
);

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  operation_ff;
   logic [8:0]  byte_offset_ff;
   logic [3:0]  access_bytes_ff;
   logic [31:0] write_data_ff;
   logic [31:0] elapsed_cycles_ff;
   logic        elapsed_too_wide_ff;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] read_data_ff;
   logic        irq_line_ff;
   logic        advance;
   logic        accept;
   logic [31:0] bank_read_data;
   logic        bank_irq;

   // Handshake
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input word register
   always_ff @(posedge clock) begin
      if (accept) begin
         operation_ff        <= req_operation;
         byte_offset_ff      <= req_byte_offset;
         access_bytes_ff     <= req_access_bytes;
         write_data_ff       <= req_write_data;
         elapsed_cycles_ff   <= req_elapsed_cycles;
         elapsed_too_wide_ff <= req_elapsed_too_wide;
      end
   end

   pcu_bank u_bank (
      .clock            (clock),
      .reset            (reset),
      .exec             (advance),
      .operation        (operation_ff),
      .byte_offset      (byte_offset_ff),
      .access_bytes     (access_bytes_ff),
      .write_data       (write_data_ff),
      .elapsed_cycles   (elapsed_cycles_ff),
      .elapsed_too_wide (elapsed_too_wide_ff),
      .read_data        (bank_read_data),
      .irq_next         (bank_irq)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (advance) begin
         read_data_ff <= bank_read_data;
         irq_line_ff  <= bank_irq;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = read_data_ff;
   assign rsp_irq_line  = irq_line_ff;

endmodule

### verif/cycle_performance_counter_unit_checker.sv
// Watches both channels of the counter bank, keeps its own copy of the bank
// state, predicts one response per accepted request word and compares.
module cycle_performance_counter_unit_checker
   import pcu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [8:0]  req_byte_offset,
   input  logic [3:0]  req_access_bytes,
   input  logic [31:0] req_write_data,
   input  logic [31:0] req_elapsed_cycles,
   input  logic        req_elapsed_too_wide,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_read_data,
   input  logic        rsp_irq_line,
   output int          error_count,
   output int          outstanding
);

   // Status bits: overflow and interrupt cause
   localparam logic [4:0] STAT_OVF   = 5'h01;
   localparam logic [4:0] STAT_INT   = 5'h10;
   localparam logic [4:0] STAT_CLEAR = 5'h11;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_line;
   } rsp_word_type;

   // Shadow copy of the bank
   logic        bank_enable;
   logic        irq_level;
   logic [31:0] count_val  [NUM_COUNTERS];
   logic [31:0] count_ctrl [NUM_COUNTERS];
   logic [4:0]  count_stat [NUM_COUNTERS];

   rsp_word_type due_responses[$];

   initial error_count = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   task automatic clear_bank();
      bank_enable = 1'b0;
      irq_level = 1'b0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
         count_val[i] = '0;
         count_ctrl[i] = '0;
         count_stat[i] = '0;
      end
   endtask

   // Interrupt level: enable AND any overflow flag
   function automatic logic irq_from_bank();
      logic any_ovf;
      any_ovf = 1'b0;
      for (int i = 0; i < NUM_COUNTERS; i++)
         any_ovf |= count_stat[i][0];
      return bank_enable & any_ovf;
   endfunction

   // Apply one request word to the shadow bank and queue its response
   task automatic execute_word(input logic [1:0] op, input logic [8:0] off,
                               input logic [3:0] size, input logic [31:0] wdata,
                               input logic [31:0] cycles, input logic wide);
      rsp_word_type due;
      logic        word_ok;
      logic        mapped;
      logic        irq_before;
      logic [31:0] total;
      region_type  region;
      int          lane;
      due.read_data = '0;
      word_ok = (off[1:0] == 2'b00) && (size == ACCESS_WORD);
      region = region_type'(off[8:7]);
      lane = int'(off[6:2]);
      if (region == REGION_GLOBAL)
         mapped = (off[6:0] == 7'd0);
      else
         mapped = (lane < NUM_COUNTERS);

      if (op == OP_READ && word_ok && mapped) begin
         case (region)
            REGION_GLOBAL:  due.read_data = {31'd0, bank_enable};
            REGION_COUNTER: due.read_data = count_val[lane];
            REGION_CONTROL: due.read_data = count_ctrl[lane];
            REGION_STATUS:  due.read_data = {27'd0, count_stat[lane]};
            default:        ;
         endcase
      end else if (op == OP_WRITE && word_ok) begin
         if (mapped) begin
            case (region)
               REGION_GLOBAL:  bank_enable = wdata[0];
               REGION_COUNTER: count_val[lane] = wdata;
               REGION_CONTROL: count_ctrl[lane] = wdata & CTRL_MASK;
               REGION_STATUS:  count_stat[lane] &= ~(wdata[4:0] & STAT_CLEAR);
               default:        ;
            endcase
         end
         irq_level = irq_from_bank();
      end else if (op == OP_TICK) begin
         // Tick: only counters with a nonzero select advance
         if (bank_enable) begin
            irq_before = irq_level;
            for (int i = 0; i < NUM_COUNTERS; i++) begin
               if (count_ctrl[i][31:16] != 16'd0) begin
                  total = count_val[i] + cycles;
                  if ((count_val[i][31] && !total[31]) || wide) begin
                     count_stat[i] |= STAT_OVF;
                     if (count_ctrl[i][0] && !irq_before)
                        count_stat[i] |= STAT_INT;
                  end
                  count_val[i] = total;
               end
            end
         end
         irq_level = irq_from_bank();
      end
      due.irq_line = irq_level;
      due_responses.push_back(due);
   endtask

   // Compare accepted responses, then predict for accepted requests
   always @(posedge clock) begin
      rsp_word_type due;
      if (reset) begin
         clear_bank();
         due_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_responses.size() == 0) begin
               report_mismatch("unexpected response", rsp_read_data, '0);
            end else begin
               due = due_responses.pop_front();
               if (rsp_read_data !== due.read_data)
                  report_mismatch("read_data", rsp_read_data, due.read_data);
               if (rsp_irq_line !== due.irq_line)
                  report_mismatch("irq_line", {31'd0, rsp_irq_line},
                                  {31'd0, due.irq_line});
            end
         end
         if (req_valid && !req_stall)
            execute_word(req_operation, req_byte_offset, req_access_bytes,
                         req_write_data, req_elapsed_cycles, req_elapsed_too_wide);
      end
      outstanding = due_responses.size();
   end

endmodule

### verif/cycle_performance_counter_unit_tb.sv
module cycle_performance_counter_unit_tb;
   import pcu_pkg::*;

   localparam int         RANDOM_WORDS = 925;
   localparam int         HOLD_CYCLES  = 60;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam logic [8:0] OFF_ENABLE   = 9'h000;
   localparam logic [8:0] OFF_COUNTER  = 9'h080;
   localparam logic [8:0] OFF_CONTROL  = 9'h100;
   localparam logic [8:0] OFF_STATUS   = 9'h180;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [8:0]  req_byte_offset;
   logic [3:0]  req_access_bytes;
   logic [31:0] req_write_data;
   logic [31:0] req_elapsed_cycles;
   logic        req_elapsed_too_wide;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_read_data;
   logic        rsp_irq_line;

   int error_count;
   int outstanding;
   int cycle_count = 0;
   int send_calm = 0;
   bit hold_rsp = 1'b0;

   cycle_performance_counter_unit DUT (.*);

   cycle_performance_counter_unit_checker bank_check (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("cycle_performance_counter_unit test failed");
         $finish;
      end
   end

   // Random wait draw, with occasional stretches of back-to-back words
   function automatic int idle_cycles(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0)
         calm = $urandom_range(10, 30);
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [8:0] reg_offset(input region_type region, input int lane);
      if (region == REGION_GLOBAL)
         return OFF_ENABLE;
      return {region, lane[4:0], 2'b00};
   endfunction

   // Offer one word from a falling edge; return at the falling edge after acceptance
   task automatic send_word(input logic [1:0] op, input logic [8:0] off,
                            input logic [3:0] size, input logic [31:0] wdata,
                            input logic [31:0] cycles, input logic wide);
      int gap;
      gap = idle_cycles(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation <= op;
      req_byte_offset <= off;
      req_access_bytes <= size;
      req_write_data <= wdata;
      req_elapsed_cycles <= cycles;
      req_elapsed_too_wide <= wide;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly well-formed accesses that drive counters toward overflow, some noise
   task automatic send_random_word();
      int          pick;
      int          lane;
      region_type  region;
      logic [31:0] data;
      pick = $urandom_range(0, 99);
      lane = $urandom_range(0, NUM_COUNTERS - 1);
      region = region_type'($urandom_range(0, 3));
      data = $urandom;
      if (pick < 15) begin
         send_word(2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)),
                   4'($urandom_range(1, 8)), data, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 37) begin
         send_word(OP_TICK, 9'($urandom_range(0, 511)), 4'($urandom_range(1, 8)), data,
                   $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom,
                   $urandom_range(0, 15) == 0);
      end else if (pick < 60) begin
         send_word(OP_READ, reg_offset(region, lane), ACCESS_WORD, data, $urandom,
                   1'($urandom_range(0, 1)));
      end else begin
         case (region)
            REGION_GLOBAL:  data[0] = ($urandom_range(0, 4) != 0);
            REGION_COUNTER: if ($urandom_range(0, 1))
                               data = 32'hffffffff - $urandom_range(0, 1023);
            REGION_CONTROL: if ($urandom_range(0, 3) == 0)
                               data[31:16] = '0;
            default: ;
         endcase
         send_word(OP_WRITE, reg_offset(region, lane), ACCESS_WORD, data, $urandom,
                   1'($urandom_range(0, 1)));
      end
   endtask

   // Response side: random stall per word, one long hold-off on request
   initial begin
      int  wait_n;
      int  calm;
      bit  hold_taken;
      rsp_stall = 1'b0;
      calm = 0;
      hold_taken = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         wait_n = idle_cycles(calm);
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
         @(negedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_READ;
      req_byte_offset = '0;
      req_access_bytes = ACCESS_WORD;
      req_write_data = '0;
      req_elapsed_cycles = '0;
      req_elapsed_too_wide = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Enable, control mask, carry overflow raising the interrupt cause
      send_word(OP_READ, OFF_ENABLE, ACCESS_WORD, '0, '0, 1'b0);
      send_word(OP_WRITE, OFF_ENABLE, ACCESS_WORD, 32'h1, '0, 1'b0);
      send_word(OP_READ, OFF_ENABLE, ACCESS_WORD, '0, '0, 1'b0);
      send_word(OP_WRITE, OFF_CONTROL, ACCESS_WORD, 32'hffffffff, '0, 1'b0);
      send_word(OP_READ, OFF_CONTROL, ACCESS_WORD, '0, '0, 1'b0);
      send_word(OP_WRITE, OFF_COUNTER, ACCESS_WORD, 32'hfffffff0, '0, 1'b0);
      send_word(OP_TICK, OFF_ENABLE, ACCESS_WORD, '0, 32'h20, 1'b0);
      send_word(OP_READ, OFF_STATUS, ACCESS_WORD, '0, '0, 1'b0);
      // Too-wide tick while the interrupt is already active
      send_word(OP_WRITE, OFF_CONTROL + 9'h1c, ACCESS_WORD, 32'h00010000, '0, 1'b0);
      send_word(OP_WRITE, OFF_COUNTER + 9'h1c, ACCESS_WORD, 32'h7fffffff, '0, 1'b0);
      send_word(OP_TICK, 9'h1ff, 4'd8, 32'hffffffff, '0, 1'b1);
      send_word(OP_READ, OFF_COUNTER + 9'h1c, ACCESS_WORD, '0, '0, 1'b0);
      // Status clears drop the interrupt
      send_word(OP_WRITE, OFF_STATUS, ACCESS_WORD, 32'hffffffff, '0, 1'b0);
      send_word(OP_WRITE, OFF_STATUS + 9'h1c, ACCESS_WORD, 32'h11, '0, 1'b0);
      send_word(OP_READ, OFF_STATUS + 9'h1c, ACCESS_WORD, '0, '0, 1'b0);
      // Disabled bank ignores ticks
      send_word(OP_WRITE, OFF_ENABLE, ACCESS_WORD, 32'hfffffffe, '0, 1'b0);
      send_word(OP_TICK, OFF_ENABLE, ACCESS_WORD, '0, 32'hffffffff, 1'b1);
      // Misaligned, wrong size, unmapped, unused operation
      send_word(OP_READ, OFF_COUNTER + 9'h2, ACCESS_WORD, '0, '0, 1'b0);
      send_word(OP_WRITE, OFF_COUNTER, 4'd8, 32'h12345678, '0, 1'b0);
      send_word(OP_READ, OFF_COUNTER, 4'd1, '0, '0, 1'b0);
      send_word(OP_READ, OFF_COUNTER + 9'h20, ACCESS_WORD, '0, '0, 1'b0);
      send_word(OP_READ, 9'h1fc, ACCESS_WORD, '0, '0, 1'b0);
      send_word(OP_UNUSED, OFF_ENABLE, ACCESS_WORD, 32'h1, 32'hffffffff, 1'b1);
      send_word(OP_WRITE, 9'h040, ACCESS_WORD, 32'hffffffff, '0, 1'b0);
      send_word(OP_READ, 9'h1ff, 4'd8, '0, '0, 1'b0);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 300)
            hold_rsp = 1'b1;
         if (n == 600) begin
            req_valid <= 1'b0;
            wait (outstanding == 0);
            @(negedge clock);
         end
         send_random_word();
      end

      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (10) @(posedge clock);
      if (error_count == 0 && outstanding == 0)
         $display("cycle_performance_counter_unit test passed");
      else
         $display("cycle_performance_counter_unit test failed");
      $finish;
   end

endmodule

### sim.f
hw/rtl/pcu_pkg.sv
hw/rtl/pcu_counter.sv
hw/rtl/pcu_bank.sv
hw/rtl/cycle_performance_counter_unit.sv
verif/cycle_performance_counter_unit_checker.sv
verif/cycle_performance_counter_unit_tb.sv
